// ----- hdl/ubrc_pkg.sv -----
// Shared types, constants and helper functions of the upwind boundary row classifier.
package ubrc_pkg;

   localparam int NUM_ANGLES  = 64;
   localparam int ANGLE_W     = $clog2(NUM_ANGLES);
   localparam int CELL_W      = 10;
   localparam int GRID_W      = 11;
   localparam int COORD_W     = 12;
   localparam int SIGN_W      = 2;
   localparam int MASK_W      = 6;
   localparam int ENTRY_W     = 3 * SIGN_W + 3 * ANGLE_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam int SIGN_X_LSB   = 0;
   localparam int SIGN_Y_LSB   = SIGN_X_LSB + SIGN_W;
   localparam int SIGN_Z_LSB   = SIGN_Y_LSB + SIGN_W;
   localparam int MIRROR_X_LSB = SIGN_Z_LSB + SIGN_W;
   localparam int MIRROR_Y_LSB = MIRROR_X_LSB + ANGLE_W;
   localparam int MIRROR_Z_LSB = MIRROR_Y_LSB + ANGLE_W;

   localparam int VAC_BIT_XLO = 0;
   localparam int VAC_BIT_XHI = 1;
   localparam int VAC_BIT_YLO = 2;
   localparam int VAC_BIT_YHI = 3;
   localparam int VAC_BIT_ZLO = 4;
   localparam int VAC_BIT_ZHI = 5;

   localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'd0;
   localparam logic [SIGN_W-1:0] SIGN_POS  = 2'd1;
   localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'd2;

   localparam logic ACTION_CLASSIFY = 1'b0;
   localparam logic ACTION_LOAD     = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_X    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_Y    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_Z    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FACE_MASK = 2'd3;

   localparam logic [GRID_W-1:0] GRID_RESET = 11'd1;
   localparam logic [MASK_W-1:0] MASK_RESET = 6'd63;

   localparam logic signed [COORD_W-1:0] COORD_ONE = 12'sd1;

   typedef enum logic [1:0] {
      KIND_INTERIOR = 2'd0,
      KIND_VACUUM   = 2'd1,
      KIND_REFLECT  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [GRID_W-1:0] grid_x;
      logic [GRID_W-1:0] grid_y;
      logic [GRID_W-1:0] grid_z;
      logic [MASK_W-1:0] face_mask;
   } cfg_type;

   function automatic logic signed [COORD_W-1:0] upwind_of(logic [CELL_W-1:0] c,
                                                           logic [SIGN_W-1:0] code);
      logic signed [COORD_W-1:0] u;
      u = signed'(COORD_W'(c));
      case (code)
         SIGN_POS: u = u - COORD_ONE;
         SIGN_NEG: u = u + COORD_ONE;
         default: u = u;
      endcase
      return u;
   endfunction

   function automatic logic has_of(logic [SIGN_W-1:0] code);
      return (code == SIGN_POS) || (code == SIGN_NEG);
   endfunction

   function automatic logic outside_of(logic signed [COORD_W-1:0] u, logic has,
                                       logic [GRID_W-1:0] n);
      return has && (u[COORD_W-1] || (u[GRID_W-1:0] >= n));
   endfunction

endpackage

// ----- hdl/upwind_boundary_row_classifier.sv -----
// Top level of the upwind boundary row classifier: angle table pipeline and result register.
//
// The req channel carries one transaction per row: a classify transaction gives a cell and an
// angle, a load transaction writes one angle table entry (signs and mirror partners). Every
// transaction yields exactly one rsp transaction, in order; a load answers with all zeros.
// The csr port sets the grid size per axis and the vacuum face mask; the user must write it
// only while the block is idle, which the block itself does not enforce.
// A transaction accepted on req passes through pipeline stages one to four and the result
// register before it appears on rsp; when nothing stalls, one transaction per cycle is
// accepted back to back. Each row needs four dependent table reads (own entry, mirror across
// y, mirror across z, partner entry), each a registered read of one of two table copies with
// two read ports each. A load waits on req until all earlier classify transactions have done
// their table reads; loads written before a classify are seen by it.
// Reset clears the pipeline valids, holds req stalled and sets the registers to their reset
// values; the table contents are undefined until loaded.
// When the receiver stalls, the result stays on rsp and the four pipeline stages keep filling,
// so up to five transactions are held before req stalls.
module upwind_boundary_row_classifier (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic [ubrc_pkg::CELL_W-1:0]          req_cell_x,
   input  logic [ubrc_pkg::CELL_W-1:0]          req_cell_y,
   input  logic [ubrc_pkg::CELL_W-1:0]          req_cell_z,
   input  logic [ubrc_pkg::ANGLE_W-1:0]         req_angle,
   input  logic [ubrc_pkg::SIGN_W-1:0]          req_sign_x,
   input  logic [ubrc_pkg::SIGN_W-1:0]          req_sign_y,
   input  logic [ubrc_pkg::SIGN_W-1:0]          req_sign_z,
   input  logic [ubrc_pkg::ANGLE_W-1:0]         req_mirror_x,
   input  logic [ubrc_pkg::ANGLE_W-1:0]         req_mirror_y,
   input  logic [ubrc_pkg::ANGLE_W-1:0]         req_mirror_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_row_kind,
   output logic [ubrc_pkg::ANGLE_W-1:0]         rsp_partner,
   output logic signed [ubrc_pkg::COORD_W-1:0]  rsp_upwind_x,
   output logic signed [ubrc_pkg::COORD_W-1:0]  rsp_upwind_y,
   output logic signed [ubrc_pkg::COORD_W-1:0]  rsp_upwind_z,
   output logic                                 rsp_has_x,
   output logic                                 rsp_has_y,
   output logic                                 rsp_has_z,
   output logic                                 rsp_partner_not_interior,
   input  logic                                 csr_wr_en,
   input  logic [ubrc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ubrc_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import ubrc_pkg::*;

   typedef struct packed {
      logic              action;
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic [CELL_W-1:0] cell_z;
      logic [ANGLE_W-1:0] angle;
   } req_type;

   typedef struct packed {
      logic                      action;
      logic [CELL_W-1:0]         cell_x;
      logic [CELL_W-1:0]         cell_y;
      logic [CELL_W-1:0]         cell_z;
      logic signed [COORD_W-1:0] upwind_x;
      logic signed [COORD_W-1:0] upwind_y;
      logic signed [COORD_W-1:0] upwind_z;
      logic                      has_x;
      logic                      has_y;
      logic                      has_z;
      kind_type                  kind;
      logic                      out_y;
      logic                      out_z;
      logic [ANGLE_W-1:0]        ap;
   } row_type;

   typedef struct packed {
      kind_type                  kind;
      logic [ANGLE_W-1:0]        partner;
      logic signed [COORD_W-1:0] upwind_x;
      logic signed [COORD_W-1:0] upwind_y;
      logic signed [COORD_W-1:0] upwind_z;
      logic                      has_x;
      logic                      has_y;
      logic                      has_z;
      logic                      partner_not_interior;
   } rsp_type;

   cfg_type cfg;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;
   logic out_valid_ff, out_valid_in;

   req_type s1_ff, s1_in;
   row_type s2_ff, s2_in;
   row_type s3_ff, s3_in;
   row_type s4_ff, s4_in;
   rsp_type out_ff, out_in;

   logic en1, en2, en3, en4, en_out;
   logic load_block;
   logic req_accept;
   logic table_wr_en;
   logic [ENTRY_W-1:0] table_wr_data;

   logic [ENTRY_W-1:0] rd_own, rd_y, rd_z, rd_partner;

   row_type row_s1;
   logic [SIGN_W-1:0] sx, sy, sz;
   logic ox, oy, oz, vx, vy, vz;
   logic [SIGN_W-1:0] psx, psy, psz;
   logic pox, poy, poz;

   ubrc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   assign en_out = !out_valid_ff || !rsp_stall;
   assign en4    = !s4_valid_ff || en_out;
   assign en3    = !s3_valid_ff || en4;
   assign en2    = !s2_valid_ff || en3;
   assign en1    = !s1_valid_ff || en2;

   assign load_block = (s1_valid_ff && (s1_ff.action == ACTION_CLASSIFY))
                    || (s2_valid_ff && (s2_ff.action == ACTION_CLASSIFY))
                    || (s3_valid_ff && (s3_ff.action == ACTION_CLASSIFY));

   assign req_stall  = reset || !en1 || ((req_action == ACTION_LOAD) && load_block);
   assign req_accept = req_valid && !req_stall;

   assign table_wr_en   = req_accept && (req_action == ACTION_LOAD);
   assign table_wr_data = {req_mirror_z, req_mirror_y, req_mirror_x,
                           req_sign_z, req_sign_y, req_sign_x};

   ubrc_ram #(.DATA_W(ENTRY_W), .ADDR_W(ANGLE_W)) u_table_a (
      .clock    (clock),
      .wr_en    (table_wr_en),
      .wr_addr  (req_angle),
      .wr_data  (table_wr_data),
      .rd0_en   (en1),
      .rd0_addr (req_angle),
      .rd0_data (rd_own),
      .rd1_en   (en2),
      .rd1_addr (row_s1.ap),
      .rd1_data (rd_y)
   );

   ubrc_ram #(.DATA_W(ENTRY_W), .ADDR_W(ANGLE_W)) u_table_b (
      .clock    (clock),
      .wr_en    (table_wr_en),
      .wr_addr  (req_angle),
      .wr_data  (table_wr_data),
      .rd0_en   (en3),
      .rd0_addr (s3_in.ap),
      .rd0_data (rd_z),
      .rd1_en   (en4),
      .rd1_addr (s4_in.ap),
      .rd1_data (rd_partner)
   );

   // Stage one: classify the row from its own table entry.
   always_comb begin
      sx = rd_own[SIGN_X_LSB +: SIGN_W];
      sy = rd_own[SIGN_Y_LSB +: SIGN_W];
      sz = rd_own[SIGN_Z_LSB +: SIGN_W];
      row_s1.action   = s1_ff.action;
      row_s1.cell_x   = s1_ff.cell_x;
      row_s1.cell_y   = s1_ff.cell_y;
      row_s1.cell_z   = s1_ff.cell_z;
      row_s1.upwind_x = upwind_of(s1_ff.cell_x, sx);
      row_s1.upwind_y = upwind_of(s1_ff.cell_y, sy);
      row_s1.upwind_z = upwind_of(s1_ff.cell_z, sz);
      row_s1.has_x    = has_of(sx);
      row_s1.has_y    = has_of(sy);
      row_s1.has_z    = has_of(sz);
      ox = outside_of(row_s1.upwind_x, row_s1.has_x, cfg.grid_x);
      oy = outside_of(row_s1.upwind_y, row_s1.has_y, cfg.grid_y);
      oz = outside_of(row_s1.upwind_z, row_s1.has_z, cfg.grid_z);
      vx = (sx == SIGN_POS) ? cfg.face_mask[VAC_BIT_XLO] : cfg.face_mask[VAC_BIT_XHI];
      vy = (sy == SIGN_POS) ? cfg.face_mask[VAC_BIT_YLO] : cfg.face_mask[VAC_BIT_YHI];
      vz = (sz == SIGN_POS) ? cfg.face_mask[VAC_BIT_ZLO] : cfg.face_mask[VAC_BIT_ZHI];
      if (!(ox || oy || oz)) begin
         row_s1.kind = KIND_INTERIOR;
      end else if ((ox && vx) || (oy && vy) || (oz && vz)) begin
         row_s1.kind = KIND_VACUUM;
      end else begin
         row_s1.kind = KIND_REFLECT;
      end
      row_s1.out_y = oy;
      row_s1.out_z = oz;
      row_s1.ap    = ox ? rd_own[MIRROR_X_LSB +: ANGLE_W] : s1_ff.angle;
      if (s1_ff.action == ACTION_LOAD) begin
         row_s1.upwind_x = '0;
         row_s1.upwind_y = '0;
         row_s1.upwind_z = '0;
         row_s1.has_x    = 1'b0;
         row_s1.has_y    = 1'b0;
         row_s1.has_z    = 1'b0;
         row_s1.kind     = KIND_INTERIOR;
         row_s1.out_y    = 1'b0;
         row_s1.out_z    = 1'b0;
      end
   end

   // Stage four: classify the partner angle at the same cell.
   always_comb begin
      psx = rd_partner[SIGN_X_LSB +: SIGN_W];
      psy = rd_partner[SIGN_Y_LSB +: SIGN_W];
      psz = rd_partner[SIGN_Z_LSB +: SIGN_W];
      pox = outside_of(upwind_of(s4_ff.cell_x, psx), has_of(psx), cfg.grid_x);
      poy = outside_of(upwind_of(s4_ff.cell_y, psy), has_of(psy), cfg.grid_y);
      poz = outside_of(upwind_of(s4_ff.cell_z, psz), has_of(psz), cfg.grid_z);
   end

   always_comb begin
      s1_in.action = req_action;
      s1_in.cell_x = req_cell_x;
      s1_in.cell_y = req_cell_y;
      s1_in.cell_z = req_cell_z;
      s1_in.angle  = req_angle;
      s2_in        = row_s1;
      s3_in        = s2_ff;
      s3_in.ap     = s2_ff.out_y ? rd_y[MIRROR_Y_LSB +: ANGLE_W] : s2_ff.ap;
      s4_in        = s3_ff;
      s4_in.ap     = s3_ff.out_z ? rd_z[MIRROR_Z_LSB +: ANGLE_W] : s3_ff.ap;
      out_in.kind     = s4_ff.kind;
      out_in.partner  = (s4_ff.kind == KIND_REFLECT) ? s4_ff.ap : '0;
      out_in.upwind_x = s4_ff.upwind_x;
      out_in.upwind_y = s4_ff.upwind_y;
      out_in.upwind_z = s4_ff.upwind_z;
      out_in.has_x    = s4_ff.has_x;
      out_in.has_y    = s4_ff.has_y;
      out_in.has_z    = s4_ff.has_z;
      out_in.partner_not_interior = (s4_ff.kind == KIND_REFLECT) && (pox || poy || poz);
      s1_valid_in  = en1 ? req_accept : s1_valid_ff;
      s2_valid_in  = en2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in  = en3 ? s2_valid_ff : s3_valid_ff;
      s4_valid_in  = en4 ? s3_valid_ff : s4_valid_ff;
      out_valid_in = en_out ? s4_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= s1_in;
      end
      if (en2) begin
         s2_ff <= s2_in;
      end
      if (en3) begin
         s3_ff <= s3_in;
      end
      if (en4) begin
         s4_ff <= s4_in;
      end
      if (en_out) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid                = out_valid_ff;
   assign rsp_row_kind             = out_ff.kind;
   assign rsp_partner              = out_ff.partner;
   assign rsp_upwind_x             = out_ff.upwind_x;
   assign rsp_upwind_y             = out_ff.upwind_y;
   assign rsp_upwind_z             = out_ff.upwind_z;
   assign rsp_has_x                = out_ff.has_x;
   assign rsp_has_y                = out_ff.has_y;
   assign rsp_has_z                = out_ff.has_z;
   assign rsp_partner_not_interior = out_ff.partner_not_interior;

endmodule

// ----- hdl/ubrc_ram.sv -----
// Generic synchronous RAM with one write port and two registered read ports.
module ubrc_ram #(
   parameter int DATA_W = 24,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd0_en,
   input  logic [ADDR_W-1:0] rd0_addr,
   output logic [DATA_W-1:0] rd0_data,
   input  logic              rd1_en,
   input  logic [ADDR_W-1:0] rd1_addr,
   output logic [DATA_W-1:0] rd1_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd0_data_ff;
   logic [DATA_W-1:0] rd1_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd0_en) begin
         rd0_data_ff <= mem[rd0_addr];
      end
      if (rd1_en) begin
         rd1_data_ff <= mem[rd1_addr];
      end
   end

   assign rd0_data = rd0_data_ff;
   assign rd1_data = rd1_data_ff;

endmodule

// ----- hdl/ubrc_csr.sv -----
// Configuration registers: grid size per axis and the vacuum face mask.
module ubrc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [ubrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ubrc_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output ubrc_pkg::cfg_type               cfg
);
   import ubrc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_X: cfg_in.grid_x = csr_wr_data[GRID_W-1:0];
            CSR_GRID_Y: cfg_in.grid_y = csr_wr_data[GRID_W-1:0];
            CSR_GRID_Z: cfg_in.grid_z = csr_wr_data[GRID_W-1:0];
            CSR_FACE_MASK: cfg_in.face_mask = csr_wr_data[MASK_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_x    <= GRID_RESET;
         cfg_ff.grid_y    <= GRID_RESET;
         cfg_ff.grid_z    <= GRID_RESET;
         cfg_ff.face_mask <= MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/ubrc_checker.sv -----
// Port-level assertions for the upwind boundary row classifier and the bind that attaches them.
module ubrc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [1:0]                           rsp_row_kind,
   input logic [ubrc_pkg::ANGLE_W-1:0]         rsp_partner,
   input logic signed [ubrc_pkg::COORD_W-1:0]  rsp_upwind_x,
   input logic signed [ubrc_pkg::COORD_W-1:0]  rsp_upwind_y,
   input logic signed [ubrc_pkg::COORD_W-1:0]  rsp_upwind_z,
   input logic                                 rsp_has_x,
   input logic                                 rsp_has_y,
   input logic                                 rsp_has_z,
   input logic                                 rsp_partner_not_interior
);
   import ubrc_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row_kind) && $stable(rsp_partner)
         && $stable(rsp_upwind_x) && $stable(rsp_upwind_y) && $stable(rsp_upwind_z)
         && $stable(rsp_partner_not_interior))
      else $error("stalled rsp transaction changed");

   a_partner_only_reflect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_row_kind != KIND_REFLECT) |-> (rsp_partner == '0)
         && !rsp_partner_not_interior)
      else $error("partner fields set on a row that is not reflective");

   a_no_axis_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_x && !rsp_has_y && !rsp_has_z |-> rsp_row_kind == KIND_INTERIOR)
      else $error("row without direction components is not interior");

endmodule

bind upwind_boundary_row_classifier ubrc_checker u_ubrc_checker (.*);
